### rtl/core/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types, codes and defaults for the broadcast ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int SLOTS_DEFAULT       = 64;
  localparam int DATA_WIDTH_DEFAULT  = 32;
  localparam int READERS_DEFAULT     = 8;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam int RING_LENGTH_RESET = 64;

  localparam logic [1:0] OP_PUBLISH = 2'd0;
  localparam logic [1:0] OP_POLL    = 2'd1;
  localparam logic [1:0] OP_ATTACH  = 2'd2;

  localparam logic [1:0] STS_PUBLISHED = 2'd0;
  localparam logic [1:0] STS_DELIVERED = 2'd1;
  localparam logic [1:0] STS_EMPTY     = 2'd2;
  localparam logic [1:0] STS_ATTACHED  = 2'd3;

  localparam logic [1:0] POL_OLDEST = 2'd1;
  localparam logic [1:0] POL_NEWEST = 2'd2;

  localparam logic REG_RING_LENGTH = 1'b0;
  localparam logic REG_RESYNC      = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] publish_value;
    logic [2:0]  subscriber;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        overrun;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DATA
  } fsm_t;

endpackage
`default_nettype wire

### rtl/core/brb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/broadcast_ring_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// broadcast_ring_buffer_top
// One writer, many readers broadcast ring with per-reader resync policy.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries publish, poll and attach
//   requests; rsp channel (rsp_valid/rsp_stall/rsp) returns one result per
//   request, in order. A transfer happens when valid is high and stall low.
//   Ring slots live in one RAM, reader pointer/count pairs in a second RAM.
//   Publish, attach and non-delivering polls load the result from the
//   lookup state; a delivering poll first reads the reader RAM, then the
//   ring RAM, and loads its result from the data state. One request is in
//   flight at a time: no new request is taken until the last has loaded.
//   While rsp is stalled the finished result holds in the output register;
//   the next request is still taken and parks before its result until the
//   register frees, with no state committed before then.
//   Reset clears pointers, counts, reader valid bits and config registers;
//   ring contents are undefined until published.
//   APB: ring_length at 0x0, resync_policies at 0x4; pready is tied high.
// ----------------------------------------------------------------------------
module broadcast_ring_buffer_top #(
  parameter int SLOTS       = brb_pkg::SLOTS_DEFAULT,
  parameter int DATA_WIDTH  = brb_pkg::DATA_WIDTH_DEFAULT,
  parameter int READERS     = brb_pkg::READERS_DEFAULT,
  parameter int COUNT_WIDTH = brb_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire brb_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output brb_pkg::rsp_t      rsp
);

  import brb_pkg::*;

  localparam int PW   = $clog2(SLOTS);
  localparam int LW   = $clog2(SLOTS + 1);
  localparam int CMPW = (LW > 7) ? LW : 7;
  localparam int RIW  = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int CW   = COUNT_WIDTH;
  localparam int EW   = CW + PW;

  // configuration
  logic [6:0]  ring_length;
  logic [15:0] resync_policies;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length     <= 7'(RING_LENGTH_RESET);
      resync_policies <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_RING_LENGTH: ring_length     <= pwdata[6:0];
        REG_RESYNC:      resync_policies <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RING_LENGTH: prdata = {25'b0, ring_length};
      REG_RESYNC:      prdata = {16'b0, resync_policies};
      default:         prdata = '0;
    endcase
  end

  logic [LW-1:0] len;
  always_comb begin
    if (ring_length == 7'd0) begin
      len = LW'(1);
    end else if (CMPW'(ring_length) > CMPW'(SLOTS)) begin
      len = LW'(SLOTS);
    end else begin
      len = LW'(ring_length);
    end
  end

  // state
  fsm_t               state, state_next;
  cmd_t               item;
  logic               kvalid;
  logic [PW-1:0]      wp, wp_next;
  logic [CW-1:0]      pc, pc_next;
  logic [READERS-1:0] rvalid;
  logic [PW-1:0]      dptr, dptr_next;
  logic [CW-1:0]      dcnt, dcnt_next;
  logic               dovr, dovr_next;
  logic               rsp_load;
  rsp_t               rsp_next;

  logic               cmd_accept;
  logic               result_go;
  logic [RIW-1:0]     kidx, item_kidx;
  logic               k_in_range, item_in_range;

  assign cmd_stall     = (state != ST_IDLE);
  assign cmd_accept    = cmd_valid && !cmd_stall;
  assign result_go     = !rsp_valid || !rsp_stall;
  assign kidx          = RIW'(cmd.subscriber);
  assign item_kidx     = RIW'(item.subscriber);
  assign k_in_range    = 32'(cmd.subscriber) < READERS;
  assign item_in_range = 32'(item.subscriber) < READERS;

  // memories
  logic                  ring_we, ring_re;
  logic [PW-1:0]         ring_waddr, ring_raddr;
  logic [DATA_WIDTH-1:0] ring_wdata, ring_rdata;
  logic                  rd_we;
  logic [EW-1:0]         rd_wdata, rd_rdata;

  brb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  brb_ram #(.WIDTH(EW), .DEPTH(READERS)) u_readers (
    .clk   (clk),
    .we    (rd_we),
    .waddr (item_kidx),
    .wdata (rd_wdata),
    .re    (cmd_accept),
    .raddr (kidx),
    .rdata (rd_rdata)
  );

  // lookup datapath
  logic [CW-1:0] ecnt, gap, rcnt;
  logic [PW-1:0] eptr, rptr;
  logic          over, has;
  logic [1:0]    pol;
  logic [PW-1:0] wp_adv, dptr_adv;

  assign ecnt = kvalid ? rd_rdata[EW-1:PW] : '0;
  assign eptr = kvalid ? rd_rdata[PW-1:0] : '0;
  assign gap  = pc - ecnt;
  assign over = gap > CW'(len);
  assign pol  = resync_policies[2*item.subscriber +: 2];

  always_comb begin
    if (!over) begin
      rcnt = ecnt;
      rptr = eptr;
      has  = (gap != '0);
    end else begin
      case (pol)
        POL_OLDEST: begin
          rcnt = pc - CW'(len);
          rptr = wp;
          has  = 1'b1;
        end
        POL_NEWEST: begin
          rcnt = pc - CW'(1);
          rptr = (wp == '0) ? PW'(len - LW'(1)) : wp - PW'(1);
          has  = 1'b1;
        end
        default: begin
          rcnt = pc;
          rptr = wp;
          has  = 1'b0;
        end
      endcase
    end
  end

  assign wp_adv   = ((LW'(wp) + LW'(1)) >= len) ? '0 : wp + PW'(1);
  assign dptr_adv = ((LW'(dptr) + LW'(1)) >= len) ? '0 : dptr + PW'(1);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ring_we    = 1'b0;
    ring_waddr = wp;
    ring_wdata = DATA_WIDTH'(item.publish_value);
    ring_re    = 1'b0;
    ring_raddr = rptr;
    rd_we      = 1'b0;
    rd_wdata   = '0;
    wp_next    = wp;
    pc_next    = pc;
    dptr_next  = dptr;
    dcnt_next  = dcnt;
    dovr_next  = dovr;
    rsp_load   = 1'b0;
    rsp_next   = '{status: STS_EMPTY, read_value: '0, overrun: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (cmd_accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        case (item.operation)
          OP_PUBLISH: begin
            if (result_go) begin
              ring_we         = 1'b1;
              wp_next         = wp_adv;
              pc_next         = pc + CW'(1);
              rsp_load        = 1'b1;
              rsp_next.status = STS_PUBLISHED;
              state_next      = ST_IDLE;
            end
          end
          OP_POLL: begin
            if (!item_in_range) begin
              if (result_go) begin
                rsp_load   = 1'b1;
                state_next = ST_IDLE;
              end
            end else if (has) begin
              ring_re    = 1'b1;
              dptr_next  = rptr;
              dcnt_next  = rcnt;
              dovr_next  = over;
              state_next = ST_DATA;
            end else if (result_go) begin
              rd_we            = over;
              rd_wdata         = {rcnt, rptr};
              rsp_load         = 1'b1;
              rsp_next.overrun = over;
              state_next       = ST_IDLE;
            end
          end
          OP_ATTACH: begin
            if (result_go) begin
              rd_we           = item_in_range;
              rsp_load        = 1'b1;
              rsp_next.status = STS_ATTACHED;
              state_next      = ST_IDLE;
            end
          end
          default: begin
            if (result_go) begin
              rsp_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_DATA: begin
        if (result_go) begin
          rd_we      = 1'b1;
          rd_wdata   = {dcnt + CW'(1), dptr_adv};
          rsp_load   = 1'b1;
          rsp_next   = '{status: STS_DELIVERED, read_value: 32'(ring_rdata),
                         overrun: dovr};
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      pc        <= '0;
      rvalid    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      wp <= wp_next;
      pc <= pc_next;
      if (rd_we) begin
        rvalid[item_kidx] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      item   <= cmd;
      kvalid <= k_in_range ? rvalid[kidx] : 1'b0;
    end
    dptr <= dptr_next;
    dcnt <= dcnt_next;
    dovr <= dovr_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // checks
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> state == ST_LOOKUP)
    else $error("accepted transfer did not start a lookup");

  a_deliver_from_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA && result_go) |=> rsp_valid && rsp.status == STS_DELIVERED)
    else $error("ring read did not deliver a value");

  a_ring_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(ring_we && ring_re))
    else $error("ring written and read in the same cycle");

  a_wp_in_store: assert property (@(posedge clk) disable iff (rst)
    32'(wp) < SLOTS)
    else $error("write pointer left the store");

endmodule
`default_nettype wire
